### hw/rtl/aewu_pkg.sv
`default_nettype none
package aewu_pkg;

	localparam int PARAM_ID_W         = 12;
	localparam int PARAM_ID_BITS_DEF  = 12;
	localparam int VALUE_W            = 30;
	localparam int WORD_W             = 32;
	localparam int MAP_INDEX_W        = 6;
	localparam int MODULE_ID_W        = 8;
	localparam int CHAN_COUNT         = 32;
	localparam int CHAN_W             = $clog2(CHAN_COUNT);
	localparam int DATA_VALUE_W       = 13;

	localparam logic [MAP_INDEX_W-1:0] TRAILER_ENTRY = MAP_INDEX_W'(CHAN_COUNT);

	localparam logic [WORD_W-1:0] FILLER = 32'hffff_ffff;

	localparam int OVERFLOW_BIT = 14;

	localparam int S_TDATA_W = 56;
	localparam int M_TDATA_W = 48;

	typedef enum logic [1:0] {
		KIND_DATA    = 2'd0,
		KIND_HEADER  = 2'd1,
		KIND_RSVD    = 2'd2,
		KIND_TRAILER = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IGNORED    = 3'd0,
		ST_HEADER     = 3'd1,
		ST_SUPPRESSED = 3'd2,
		ST_WRITTEN    = 3'd3,
		ST_TRAILER    = 3'd4,
		ST_NO_TRAILER = 3'd5,
		ST_MAP        = 3'd6
	} status_t;

	typedef struct packed {
		logic                   en;
		logic [MAP_INDEX_W-1:0] index;
		logic [PARAM_ID_W-1:0]  param;
		logic                   enable;
	} map_wr_t;

	typedef struct packed {
		logic                  chan_on;
		logic [PARAM_ID_W-1:0] chan_id;
		logic                  trl_on;
		logic [PARAM_ID_W-1:0] trl_id;
	} map_rd_t;

endpackage
`default_nettype wire

### hw/rtl/aewu_map.sv
`default_nettype none
module aewu_map #(
	parameter int PARAM_ID_BITS = aewu_pkg::PARAM_ID_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire aewu_pkg::map_wr_t             wr,
	input  wire logic [aewu_pkg::CHAN_W-1:0]   chan,
	output aewu_pkg::map_rd_t                  rd
);

	localparam int IdBits = (PARAM_ID_BITS < aewu_pkg::PARAM_ID_W) ?
		PARAM_ID_BITS : aewu_pkg::PARAM_ID_W;

	logic [aewu_pkg::CHAN_COUNT-1:0] on_q;
	logic [IdBits-1:0]               id_q [aewu_pkg::CHAN_COUNT];
	logic                            trl_on_q;
	logic [IdBits-1:0]               trl_id_q;

	logic chan_wr;
	logic trl_wr;

	assign trl_wr  = wr.en && (wr.index == aewu_pkg::TRAILER_ENTRY);
	assign chan_wr = wr.en && (wr.index < aewu_pkg::TRAILER_ENTRY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_q     <= '0;
			trl_on_q <= 1'b0;
		end else begin
			if (chan_wr) begin
				on_q[wr.index[aewu_pkg::CHAN_W-1:0]] <= wr.enable;
			end
			if (trl_wr) begin
				trl_on_q <= wr.enable;
			end
		end
	end

	// ids need no reset, an entry is only read while its enable is set
	always_ff @(posedge clk) begin
		if (chan_wr) begin
			id_q[wr.index[aewu_pkg::CHAN_W-1:0]] <= wr.param[IdBits-1:0];
		end
		if (trl_wr) begin
			trl_id_q <= wr.param[IdBits-1:0];
		end
	end

	assign rd.chan_on = on_q[chan];
	assign rd.chan_id = aewu_pkg::PARAM_ID_W'(id_q[chan]);
	assign rd.trl_on  = trl_on_q;
	assign rd.trl_id  = aewu_pkg::PARAM_ID_W'(trl_id_q);

endmodule
`default_nettype wire

### hw/rtl/adc_event_word_unpacker.sv
// adc_event_word_unpacker
// Input stream: one beat per readout word or channel map write. tuser[0] selects
// the kind (0 parse word, 1 map write); tdata carries word, map_index, map_param
// and map_enable. Every accepted beat produces exactly one output beat carrying
// write_valid and status in tuser, param_id and param_value in tdata.
// Configuration: cfg_we loads cfg_wdata into the module id; write only while idle.
// Pipeline: an input beat passes through the input register, then the result
// register, before it reaches the output. Throughput: one beat per cycle while m_tready
// is high; the channel map lookup and word decode fit between the registers.
// Map writes and event open/close take effect when the beat moves into the result
// register, so the next beat always sees them.
// Reset: clears the module id, closes any open event and marks all 33 map
// entries unmapped; no clearing pass is needed, the block is ready at once.
// Stall: when m_tready is low the result register holds, one more beat waits in
// the input register, then s_tready drops until the output is taken.
`default_nettype none
module adc_event_word_unpacker #(
	parameter int PARAM_ID_BITS = aewu_pkg::PARAM_ID_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [aewu_pkg::MODULE_ID_W-1:0]   cfg_wdata,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// word[31:0], map_index[37:32], map_param[49:38], map_enable[50], zero pad
	input  wire logic [aewu_pkg::S_TDATA_W-1:0]     s_tdata,
	// func[0]
	input  wire logic [0:0]                         s_tuser,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// param_id[11:0], param_value[41:12], zero pad
	output logic [aewu_pkg::M_TDATA_W-1:0]          m_tdata,
	// write_valid[0], status[3:1]
	output logic [3:0]                              m_tuser
);

	logic [aewu_pkg::MODULE_ID_W-1:0] module_id_q;
	logic                             in_event_q;

	logic                                valid_s1;
	logic                                func_s1;
	logic [aewu_pkg::WORD_W-1:0]         word_s1;
	logic [aewu_pkg::MAP_INDEX_W-1:0]    index_s1;
	logic [aewu_pkg::PARAM_ID_W-1:0]     param_s1;
	logic                                enable_s1;

	logic                                valid_s2;
	logic                                wv_s2;
	logic [aewu_pkg::PARAM_ID_W-1:0]     id_s2;
	logic [aewu_pkg::VALUE_W-1:0]        val_s2;
	aewu_pkg::status_t                   st_s2;

	logic s_acc;
	logic out_free;
	logic adv_s1;

	aewu_pkg::kind_t   kind;
	aewu_pkg::map_wr_t map_wr;
	aewu_pkg::map_rd_t map_rd;

	logic                            nx_wv;
	logic [aewu_pkg::PARAM_ID_W-1:0] nx_id;
	logic [aewu_pkg::VALUE_W-1:0]    nx_val;
	aewu_pkg::status_t               nx_st;
	logic                            nx_in_event;

	assign out_free = !valid_s2 || m_tready;
	assign adv_s1   = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;
	assign s_acc    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			module_id_q <= '0;
		end else if (cfg_we) begin
			module_id_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			in_event_q <= 1'b0;
		end else begin
			if (s_acc) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2   <= 1'b1;
				in_event_q <= nx_in_event;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			func_s1   <= s_tuser[0];
			word_s1   <= s_tdata[31:0];
			index_s1  <= s_tdata[37:32];
			param_s1  <= s_tdata[49:38];
			enable_s1 <= s_tdata[50];
		end
		if (adv_s1) begin
			wv_s2  <= nx_wv;
			id_s2  <= nx_id;
			val_s2 <= nx_val;
			st_s2  <= nx_st;
		end
	end

	assign kind = aewu_pkg::kind_t'(word_s1[31:30]);

	assign map_wr.en     = adv_s1 && func_s1;
	assign map_wr.index  = index_s1;
	assign map_wr.param  = param_s1;
	assign map_wr.enable = enable_s1;

	aewu_map #(
		.PARAM_ID_BITS(PARAM_ID_BITS)
	) u_map (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (map_wr),
		.chan  (word_s1[16 +: aewu_pkg::CHAN_W]),
		.rd    (map_rd)
	);

	always_comb begin
		nx_wv       = 1'b0;
		nx_id       = '0;
		nx_val      = '0;
		nx_st       = aewu_pkg::ST_IGNORED;
		nx_in_event = in_event_q;
		if (func_s1) begin
			if (index_s1 <= aewu_pkg::TRAILER_ENTRY) begin
				nx_st = aewu_pkg::ST_MAP;
			end
		end else if (!in_event_q) begin
			if (word_s1 != aewu_pkg::FILLER && kind == aewu_pkg::KIND_HEADER &&
					word_s1[23:16] == module_id_q) begin
				nx_st       = aewu_pkg::ST_HEADER;
				nx_in_event = 1'b1;
			end
		end else begin
			case (kind)
				aewu_pkg::KIND_DATA: begin
					nx_st = aewu_pkg::ST_SUPPRESSED;
					if (!word_s1[aewu_pkg::OVERFLOW_BIT] && map_rd.chan_on) begin
						nx_st  = aewu_pkg::ST_WRITTEN;
						nx_wv  = 1'b1;
						nx_id  = map_rd.chan_id;
						nx_val = aewu_pkg::VALUE_W'(word_s1[aewu_pkg::DATA_VALUE_W-1:0]);
					end
				end
				aewu_pkg::KIND_TRAILER: begin
					nx_st       = aewu_pkg::ST_TRAILER;
					nx_in_event = 1'b0;
					if (map_rd.trl_on) begin
						nx_wv  = 1'b1;
						nx_id  = map_rd.trl_id;
						nx_val = word_s1[aewu_pkg::VALUE_W-1:0];
					end
				end
				default: begin
					nx_st       = aewu_pkg::ST_NO_TRAILER;
					nx_in_event = 1'b0;
				end
			endcase
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'd0, val_s2, id_s2};
	assign m_tuser  = {st_s2, wv_s2};

`ifndef ASSERT_OFF
	a_wv_status: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && wv_s2 |-> st_s2 == aewu_pkg::ST_WRITTEN || st_s2 == aewu_pkg::ST_TRAILER)
		else $error("write_valid with a status that cannot write");

	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !wv_s2 |-> id_s2 == '0 && val_s2 == '0)
		else $error("payload not zero on a beat without a write");

	a_event_open: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_event_q) |-> valid_s2 && st_s2 == aewu_pkg::ST_HEADER)
		else $error("event opened without a header result");

	a_event_close: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_event_q) |-> valid_s2 &&
			(st_s2 == aewu_pkg::ST_TRAILER || st_s2 == aewu_pkg::ST_NO_TRAILER))
		else $error("event closed without a trailer or missing trailer result");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && (!valid_s2 || m_tready) |=> valid_s2)
		else $error("input register beat lost");
`endif

endmodule
`default_nettype wire
